[rtl/falc_pkg.sv]
// Shared constants for the fully associative line cache: operation codes,
// field widths of the stream items and default sizes. No dependencies.
`default_nettype none

package falc_pkg;

    localparam int OPCODE_BITS     = 2;
    localparam int FILL_WORDS      = 4;
    localparam int SLOT_FIELD_BITS = 3;

    localparam int DEF_NUM_SLOTS  = 8;
    localparam int DEF_LINE_WORDS = 4;
    localparam int DEF_ADDR_BITS  = 16;
    localparam int DEF_WORD_BITS  = 16;

    localparam logic [OPCODE_BITS-1:0] OP_READ  = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_WRITE = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_FILL  = 2'd2;

endpackage

`default_nettype wire

[rtl/fully_assoc_lru_cache.sv]
// Fully associative line cache with exact least-recently-used replacement.
// Depends on falc_pkg for operation codes, field widths and default sizes.
// Use: each input item is a read, a write, a line fill or an unused operation; each gives one result.
//   Input channel s_*: tdata holds opcode, address, write_value, fill_dirty and
//   fill_word0..fill_word3, lowest bits first, zero padded to whole bytes.
//   Output channel m_*: tdata holds hit, read_value, slot_index, evicted_valid,
//   evicted_dirty, evicted_base and evicted_word0..evicted_word3, lowest first.
// An accepted item is registered together with its line base and offset, then
// compared against all tags in parallel; the cache state and the result
// register are written at the end of that compare. The result then appears on
// m_tvalid from the result register, and one item is taken per cycle while the
// receiver does not stall, set by the single tag compare and rank update stage.
// Each slot keeps a recency rank, so the least recently used slot is the one
// whose rank equals NUM_SLOTS-1 once the cache is full.
// Reset clears all valid bits, dirty bits and ranks; tags and data are then
// unused until filled. When the receiver stalls, the result register holds
// its item, the input register holds the next one, and s_tready drops.
`default_nettype none

module fully_assoc_lru_cache #(
    parameter int NUM_SLOTS  = falc_pkg::DEF_NUM_SLOTS,
    parameter int LINE_WORDS = falc_pkg::DEF_LINE_WORDS,
    parameter int ADDR_BITS  = falc_pkg::DEF_ADDR_BITS,
    parameter int WORD_BITS  = falc_pkg::DEF_WORD_BITS,
    localparam int IN_RAW    = falc_pkg::OPCODE_BITS + ADDR_BITS + WORD_BITS + 1
                               + falc_pkg::FILL_WORDS * WORD_BITS,
    localparam int IN_BITS   = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW   = 1 + WORD_BITS + falc_pkg::SLOT_FIELD_BITS + 2 + ADDR_BITS
                               + falc_pkg::FILL_WORDS * WORD_BITS,
    localparam int OUT_BITS  = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // opcode, address, write_value, fill_dirty, fill_word0..fill_word3
    input  wire logic [IN_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // hit, read_value, slot_index, evicted_valid, evicted_dirty, evicted_base,
    // evicted_word0..evicted_word3
    output logic [OUT_BITS-1:0]      m_tdata
);

    localparam int FW        = falc_pkg::FILL_WORDS;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int RANK_BITS = $clog2(NUM_SLOTS);
    localparam int LSH       = $clog2(LINE_WORDS);
    localparam int OFF_BITS  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int PROD_BITS = 2 * ADDR_BITS + LSH + 1;

    localparam int IN_ADDR_LSB   = falc_pkg::OPCODE_BITS;
    localparam int IN_WVAL_LSB   = IN_ADDR_LSB + ADDR_BITS;
    localparam int IN_FDIRTY_BIT = IN_WVAL_LSB + WORD_BITS;
    localparam int IN_FWORD_LSB  = IN_FDIRTY_BIT + 1;

    localparam logic [ADDR_BITS:0] RECIP = (ADDR_BITS + 1)'(
        ((64'd1 << (ADDR_BITS + LSH)) + 64'(LINE_WORDS) - 64'd1) / 64'(LINE_WORDS));
    localparam logic [ADDR_BITS-1:0] LW_A     = ADDR_BITS'(LINE_WORDS);
    localparam logic [RANK_BITS-1:0] LRU_RANK = RANK_BITS'(NUM_SLOTS - 1);

    // Input stage.
    logic                                in_valid_reg;
    logic [falc_pkg::OPCODE_BITS-1:0]    op_reg;
    logic [ADDR_BITS-1:0]                base_reg;
    logic [OFF_BITS-1:0]                 offset_reg;
    logic [WORD_BITS-1:0]                wval_reg;
    logic                                fdirty_reg;
    logic [WORD_BITS-1:0]                fword_reg [FW];

    logic [ADDR_BITS-1:0]                in_addr;
    logic [PROD_BITS-1:0]                in_prod;
    logic [ADDR_BITS-1:0]                in_quot;
    logic [ADDR_BITS-1:0]                in_base;
    logic [ADDR_BITS-1:0]                in_off;

    // Cache state.
    logic [NUM_SLOTS-1:0]                valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]                dirty_reg, dirty_next;
    logic [RANK_BITS-1:0]                rank_reg [NUM_SLOTS];
    logic [RANK_BITS-1:0]                rank_next [NUM_SLOTS];
    logic [ADDR_BITS-1:0]                tag_reg [NUM_SLOTS];
    logic [WORD_BITS-1:0]                word_reg [NUM_SLOTS][LINE_WORDS];

    // Output stage.
    logic                                out_valid_reg;
    logic [OUT_BITS-1:0]                 out_data_reg, out_data_next;

    // Lookup and replacement.
    logic                                advance;
    logic                                is_rw, is_read, is_write, is_fill;
    logic [NUM_SLOTS-1:0]                match, hit_oh, free_oh, lru_oh, vic_oh, tgt_oh;
    logic                                hit_any, all_valid, do_touch, tgt_was_valid;
    logic [RANK_BITS-1:0]                tgt_rank;
    logic [SLOT_BITS-1:0]                tgt_idx;
    logic [WORD_BITS-1:0]                hit_line [LINE_WORDS];
    logic [WORD_BITS-1:0]                hit_word;
    logic [WORD_BITS-1:0]                ev_line [LINE_WORDS];
    logic [WORD_BITS-1:0]                ev_word [FW];
    logic [ADDR_BITS-1:0]                ev_tag;
    logic                                ev_dirty_sel;
    logic                                res_hit, res_ev_valid, res_ev_dirty;
    logic [WORD_BITS-1:0]                res_read;
    logic [falc_pkg::SLOT_FIELD_BITS-1:0] res_slot;
    logic [ADDR_BITS-1:0]                res_ev_base;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Line base and offset by reciprocal multiplication.
    assign in_addr = s_tdata[IN_ADDR_LSB +: ADDR_BITS];
    assign in_prod = PROD_BITS'(in_addr) * PROD_BITS'(RECIP);
    assign in_quot = in_prod[ADDR_BITS + LSH +: ADDR_BITS];
    assign in_base = in_quot * LW_A;
    assign in_off  = in_addr - in_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg     <= s_tdata[falc_pkg::OPCODE_BITS-1:0];
            base_reg   <= in_base;
            offset_reg <= in_off[OFF_BITS-1:0];
            wval_reg   <= s_tdata[IN_WVAL_LSB +: WORD_BITS];
            fdirty_reg <= s_tdata[IN_FDIRTY_BIT];
            for (int j = 0; j < FW; j++)
            begin
                fword_reg[j] <= s_tdata[IN_FWORD_LSB + j * WORD_BITS +: WORD_BITS];
            end
        end
    end

    always_comb
    begin
        is_read  = (op_reg == falc_pkg::OP_READ);
        is_write = (op_reg == falc_pkg::OP_WRITE);
        is_fill  = (op_reg == falc_pkg::OP_FILL);
        is_rw    = is_read || is_write;

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            match[i]  = valid_reg[i] && (tag_reg[i] == base_reg);
            lru_oh[i] = (rank_reg[i] == LRU_RANK);
        end
        hit_oh    = match & (~match + NUM_SLOTS'(1));
        hit_any   = |match;
        free_oh   = ~valid_reg & (valid_reg + NUM_SLOTS'(1));
        all_valid = &valid_reg;
        vic_oh    = all_valid ? lru_oh : free_oh;
        tgt_oh    = is_fill ? vic_oh : hit_oh;
        do_touch  = (is_rw && hit_any) || is_fill;

        tgt_rank      = '0;
        tgt_idx       = '0;
        tgt_was_valid = 1'b0;
        ev_tag        = '0;
        ev_dirty_sel  = 1'b0;
        for (int j = 0; j < LINE_WORDS; j++)
        begin
            hit_line[j] = '0;
            ev_line[j]  = '0;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (tgt_oh[i])
            begin
                tgt_rank      = tgt_rank | rank_reg[i];
                tgt_idx       = tgt_idx | SLOT_BITS'(i);
                tgt_was_valid = tgt_was_valid | valid_reg[i];
            end
            if (vic_oh[i])
            begin
                ev_tag       = ev_tag | tag_reg[i];
                ev_dirty_sel = ev_dirty_sel | dirty_reg[i];
            end
            for (int j = 0; j < LINE_WORDS; j++)
            begin
                if (hit_oh[i])
                begin
                    hit_line[j] = hit_line[j] | word_reg[i][j];
                end
                if (vic_oh[i])
                begin
                    ev_line[j] = ev_line[j] | word_reg[i][j];
                end
            end
        end

        hit_word = '0;
        for (int j = 0; j < LINE_WORDS; j++)
        begin
            if (offset_reg == OFF_BITS'(j))
            begin
                hit_word = hit_line[j];
            end
        end

        for (int j = 0; j < FW; j++)
        begin
            ev_word[j] = '0;
            if (j < LINE_WORDS && is_fill && all_valid)
            begin
                ev_word[j] = ev_line[j];
            end
        end

        res_hit      = is_rw && hit_any;
        res_read     = (is_read && hit_any) ? hit_word : '0;
        res_slot     = do_touch ? falc_pkg::SLOT_FIELD_BITS'(tgt_idx) : '0;
        res_ev_valid = is_fill && all_valid;
        res_ev_dirty = res_ev_valid && ev_dirty_sel;
        res_ev_base  = res_ev_valid ? ev_tag : '0;

        out_data_next = OUT_BITS'({ev_word[3], ev_word[2], ev_word[1], ev_word[0],
                                   res_ev_base, res_ev_dirty, res_ev_valid,
                                   res_slot, res_read, res_hit});

        valid_next = valid_reg;
        dirty_next = dirty_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_touch)
            begin
                if (tgt_oh[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (!tgt_was_valid || rank_reg[i] < tgt_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_BITS'(1);
                end
            end
            if (tgt_oh[i] && is_fill)
            begin
                valid_next[i] = 1'b1;
                dirty_next[i] = fdirty_reg;
            end
            else if (tgt_oh[i] && is_write && hit_any)
            begin
                dirty_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                valid_reg     <= valid_next;
                dirty_reg     <= dirty_next;
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (tgt_oh[i] && is_fill)
                begin
                    tag_reg[i] <= base_reg;
                    for (int j = 0; j < LINE_WORDS; j++)
                    begin
                        word_reg[i][j] <= (j < FW) ? fword_reg[j] : '0;
                    end
                end
                else if (tgt_oh[i] && is_write && hit_any)
                begin
                    for (int j = 0; j < LINE_WORDS; j++)
                    begin
                        if (offset_reg == OFF_BITS'(j))
                        begin
                            word_reg[i][j] <= wval_reg;
                        end
                    end
                end
            end
        end
    end

    // A full cache always has exactly one least recently used slot.
    a_single_lru: assert property (@(posedge clk) disable iff (!rst_n)
        all_valid |-> $onehot(lru_oh))
        else $error("full cache does not have exactly one LRU slot");

    // The slot touched by an item becomes the most recent one.
    a_touch_rank: assert property (@(posedge clk) disable iff (!rst_n)
        advance && do_touch |=> rank_reg[$past(tgt_idx)] == '0)
        else $error("touched slot is not most recent");

    // A fill into a free slot adds exactly one valid line.
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_fill && !all_valid |=>
            $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("fill into a free slot did not add one line");

endmodule

`default_nettype wire

[test/tb_fully_assoc_lru_cache.sv]
// Self-checking testbench for fully_assoc_lru_cache: a behavioral cache model
// predicts every result of a stream of reads, writes and line fills.
// Depends on falc_pkg and the fully_assoc_lru_cache RTL.
`default_nettype none

module tb_fully_assoc_lru_cache;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = falc_pkg::DEF_NUM_SLOTS;
    localparam int LINE_LEN = falc_pkg::DEF_LINE_WORDS;
    localparam int AW       = falc_pkg::DEF_ADDR_BITS;
    localparam int WW       = falc_pkg::DEF_WORD_BITS;
    localparam int OPB      = falc_pkg::OPCODE_BITS;
    localparam int FWN      = falc_pkg::FILL_WORDS;
    localparam int SFB      = falc_pkg::SLOT_FIELD_BITS;
    localparam int IN_RAW   = OPB + AW + WW + 1 + FWN * WW;
    localparam int IN_BITS  = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW  = 1 + WW + SFB + 2 + AW + FWN * WW;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;
    localparam int POOL_LEN = 12;
    localparam int RANDOM_ITEMS = 1000;

    localparam logic [OPB-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [IN_BITS-IN_RAW-1:0] pad;
        logic [WW-1:0]             fill_word3;
        logic [WW-1:0]             fill_word2;
        logic [WW-1:0]             fill_word1;
        logic [WW-1:0]             fill_word0;
        logic                      fill_dirty;
        logic [WW-1:0]             write_value;
        logic [AW-1:0]             address;
        logic [OPB-1:0]            opcode;
    } cache_req_t;

    typedef struct packed {
        logic [OUT_BITS-OUT_RAW-1:0] pad;
        logic [WW-1:0]               evicted_word3;
        logic [WW-1:0]               evicted_word2;
        logic [WW-1:0]               evicted_word1;
        logic [WW-1:0]               evicted_word0;
        logic [AW-1:0]               evicted_base;
        logic                        evicted_dirty;
        logic                        evicted_valid;
        logic [SFB-1:0]              slot_index;
        logic [WW-1:0]               read_value;
        logic                        hit;
    } cache_result_t;

    typedef struct {
        cache_req_t req;
        bit         drain_first;
    } pending_req_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SLUGGISH,
        RX_ALTERNATE
    } rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;

    pending_req_t  pending_reqs[$];
    cache_result_t expected_results[$];
    int            fail_count = 0;

    // Model of the cache contents.
    logic          line_valid[SLOTS] = '{default: 1'b0};
    logic          line_dirty[SLOTS] = '{default: 1'b0};
    logic [AW-1:0] line_tag[SLOTS] = '{default: '0};
    int            line_rank[SLOTS] = '{default: 0};
    logic [WW-1:0] line_word[SLOTS][LINE_LEN] = '{default: '{default: '0}};

    fully_assoc_lru_cache DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic void make_most_recent(int slot);
        int old_rank;
        old_rank = line_rank[slot];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i != slot && line_valid[i] && line_rank[i] < old_rank)
                line_rank[i]++;
        end
        line_rank[slot] = 0;
    endfunction

    function automatic cache_result_t cache_access(cache_req_t req);
        cache_result_t res;
        logic [AW-1:0] base;
        logic [WW-1:0] fill_line[FWN];
        int            offset;
        int            slot;
        res = '0;
        offset = req.address % LINE_LEN;
        base = req.address - AW'(offset);
        slot = -1;
        if (req.opcode == falc_pkg::OP_READ || req.opcode == falc_pkg::OP_WRITE)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (line_valid[i] && line_tag[i] == base)
                    slot = i;
            end
            if (slot >= 0)
            begin
                if (req.opcode == falc_pkg::OP_READ)
                    res.read_value = line_word[slot][offset];
                else
                begin
                    line_word[slot][offset] = req.write_value;
                    line_dirty[slot] = 1'b1;
                end
                make_most_recent(slot);
                res.hit = 1'b1;
                res.slot_index = SFB'(slot);
            end
        end
        else if (req.opcode == falc_pkg::OP_FILL)
        begin
            for (int i = 0; i < SLOTS && slot < 0; i++)
            begin
                if (!line_valid[i])
                    slot = i;
            end
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < SLOTS; i++)
                begin
                    if (line_rank[i] > line_rank[slot])
                        slot = i;
                end
                res.evicted_valid = 1'b1;
                res.evicted_dirty = line_dirty[slot];
                res.evicted_base  = line_tag[slot];
                res.evicted_word0 = line_word[slot][0];
                res.evicted_word1 = line_word[slot][1];
                res.evicted_word2 = line_word[slot][2];
                res.evicted_word3 = line_word[slot][3];
            end
            else
                line_rank[slot] = SLOTS;
            fill_line = '{req.fill_word0, req.fill_word1, req.fill_word2, req.fill_word3};
            line_valid[slot] = 1'b1;
            line_dirty[slot] = req.fill_dirty;
            line_tag[slot] = base;
            for (int j = 0; j < LINE_LEN; j++)
                line_word[slot][j] = fill_line[j];
            make_most_recent(slot);
            res.slot_index = SFB'(slot);
        end
        return res;
    endfunction

    function automatic string result_diff(cache_result_t got, cache_result_t want);
        string fields;
        fields = "";
        if (got.hit != want.hit) fields = {fields, " hit"};
        if (got.read_value != want.read_value) fields = {fields, " read_value"};
        if (got.slot_index != want.slot_index) fields = {fields, " slot_index"};
        if (got.evicted_valid != want.evicted_valid) fields = {fields, " evicted_valid"};
        if (got.evicted_dirty != want.evicted_dirty) fields = {fields, " evicted_dirty"};
        if (got.evicted_base != want.evicted_base) fields = {fields, " evicted_base"};
        if (got.evicted_word0 != want.evicted_word0) fields = {fields, " evicted_word0"};
        if (got.evicted_word1 != want.evicted_word1) fields = {fields, " evicted_word1"};
        if (got.evicted_word2 != want.evicted_word2) fields = {fields, " evicted_word2"};
        if (got.evicted_word3 != want.evicted_word3) fields = {fields, " evicted_word3"};
        return fields;
    endfunction

    function automatic cache_req_t random_req(logic [OPB-1:0] op, logic [AW-1:0] addr);
        cache_req_t req;
        req = '0;
        req.opcode = op;
        req.address = addr;
        req.write_value = WW'($urandom);
        req.fill_dirty = 1'($urandom);
        req.fill_word0 = WW'($urandom);
        req.fill_word1 = WW'($urandom);
        req.fill_word2 = WW'($urandom);
        req.fill_word3 = WW'($urandom);
        return req;
    endfunction

    function automatic void queue_req(cache_req_t req, bit drain_first);
        pending_reqs.push_back('{req: req, drain_first: drain_first});
    endfunction

    function automatic void queue_fill(logic [AW-1:0] addr, logic dirty,
                                       logic [WW-1:0] w0, logic [WW-1:0] w1,
                                       logic [WW-1:0] w2, logic [WW-1:0] w3);
        cache_req_t req;
        req = random_req(falc_pkg::OP_FILL, addr);
        req.fill_dirty = dirty;
        req.fill_word0 = w0;
        req.fill_word1 = w1;
        req.fill_word2 = w2;
        req.fill_word3 = w3;
        queue_req(req, 1'b0);
    endfunction

    function automatic void queue_write(logic [AW-1:0] addr, logic [WW-1:0] value);
        cache_req_t req;
        req = random_req(falc_pkg::OP_WRITE, addr);
        req.write_value = value;
        queue_req(req, 1'b0);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(cache_access(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0
                         && !(pending_reqs[0].drain_first && expected_results.size() != 0))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_reqs[0].req;
                    void'(pending_reqs.pop_front());
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(60);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result and stalls in randomly chosen modes.
    rx_mode_t      rx_mode;
    int            rx_mode_left;
    cache_result_t got_result;
    cache_result_t want_result;
    string         bad_fields;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_mode = RX_ALWAYS;
            rx_mode_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_result = m_tdata;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: result with no item outstanding: %h", $realtime, got_result);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    bad_fields = result_diff(got_result, want_result);
                    if (bad_fields != "")
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t: mismatch in%s: expected %h, got %h", $realtime,
                                     bad_fields, want_result, got_result);
                    end
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(3));
                rx_mode_left = $urandom_range(20, 200);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                RX_ALWAYS:    m_tready <= 1'b1;
                RX_COIN:      m_tready <= 1'($urandom);
                RX_SLUGGISH:  m_tready <= ($urandom_range(3) == 0);
                RX_ALTERNATE: m_tready <= ~m_tready;
                default:      m_tready <= 1'b1;
            endcase
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_fully_assoc_lru_cache NOT OK");
        $finish;
    end

    logic [AW-1:0] base_pool[POOL_LEN];
    logic [AW-1:0] pick_base;
    int            pick;

    initial
    begin
        // Misses on an empty cache and an unused operation.
        queue_req(random_req(falc_pkg::OP_READ, 16'h0000), 1'b0);
        queue_write(16'hFFFF, 16'h7FFF);
        queue_req(random_req(OP_UNUSED, 16'hFFFF), 1'b0);
        // Eight fills occupy every slot; two of them use unaligned addresses.
        queue_fill(16'h0000, 1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        queue_fill(16'hFFFF, 1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
        queue_fill(16'h1235, 1'b0, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
        queue_fill(16'h4000, 1'b1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        queue_fill(16'h8000, 1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        queue_fill(16'hA5A4, 1'b0, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
        queue_fill(16'h5A58, 1'b1, 16'hFFFE, 16'hFFFD, 16'hFFFC, 16'hFFFB);
        queue_fill(16'h0004, 1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        // Hits at the last word of one line and inside another, then writes of the extreme words.
        queue_req(random_req(falc_pkg::OP_READ, 16'h0003), 1'b0);
        queue_req(random_req(falc_pkg::OP_READ, 16'hFFFE), 1'b0);
        queue_write(16'h0001, 16'h8000);
        queue_write(16'hFFFC, 16'h7FFF);
        queue_req(random_req(falc_pkg::OP_READ, 16'h0001), 1'b0);
        // A line already cached is placed again over the least recent slot.
        queue_fill(16'h0000, 1'b1, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0);
        queue_req(random_req(falc_pkg::OP_READ, 16'h0002), 1'b0);
        queue_fill(16'h2222, 1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        queue_fill(16'h3333, 1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_req(random_req(falc_pkg::OP_READ, 16'h3330), 1'b0);

        // Random traffic over a small pool of lines, larger than the cache.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                for (int k = 0; k < POOL_LEN; k++)
                    base_pool[k] = AW'($urandom) & ~AW'(LINE_LEN - 1);
                base_pool[0] = 16'h0000;
                base_pool[1] = 16'hFFFC;
            end
            pick_base = base_pool[$urandom_range(POOL_LEN - 1)];
            pick = $urandom_range(99);
            if (pick < 25)
                queue_req(random_req(falc_pkg::OP_FILL, pick_base | AW'($urandom_range(3))),
                          n == 500);
            else if (pick < 55)
                queue_req(random_req(falc_pkg::OP_READ, pick_base | AW'($urandom_range(3))),
                          n == 500);
            else if (pick < 85)
                queue_req(random_req(falc_pkg::OP_WRITE, pick_base | AW'($urandom_range(3))),
                          n == 500);
            else if (pick < 95)
                queue_req(random_req(OPB'($urandom_range(1)), AW'($urandom)), n == 500);
            else
                queue_req(random_req(OP_UNUSED, AW'($urandom)), n == 500);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_fully_assoc_lru_cache OK");
        else
            $display("tb_fully_assoc_lru_cache NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/falc_pkg.sv
rtl/fully_assoc_lru_cache.sv
test/tb_fully_assoc_lru_cache.sv
